// File: hdl/settable_clock_display_scanner_macros.svh
// ----------------------------------------------------------------------------
// settable_clock_display_scanner_macros
// Assertion macros used by the clock display scanner core (scs_clock_core).
// ----------------------------------------------------------------------------
`ifndef SETTABLE_CLOCK_DISPLAY_SCANNER_MACROS_SVH
`define SETTABLE_CLOCK_DISPLAY_SCANNER_MACROS_SVH

// check a condition at every clock edge out of reset
`define SCS_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// check a consequence in the cycle after an antecedent
`define SCS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg
// Types, constants and digit helpers for the clock display scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package scs_pkg;

	localparam int BLINK_LAST = 3;
	localparam int BLINK_W    = $clog2(BLINK_LAST + 1);

	localparam logic [9:0] RELOAD_RESET = 10'd993;
	localparam logic [9:0] TICK_RESET   = 10'd1000;

	localparam logic [5:0] SEC_RESET  = 6'd24;
	localparam logic [5:0] MIN_RESET  = 6'd35;
	localparam logic [4:0] HOUR_RESET = 5'd22;
	localparam logic [5:0] SEC_LAST   = 6'd59;
	localparam logic [5:0] MIN_LAST   = 6'd59;
	localparam logic [4:0] HOUR_LAST  = 5'd23;

	localparam int         NUM_DIGITS      = 6;
	localparam logic [2:0] SCAN_WRAP       = 3'd6;
	localparam logic [2:0] KEY_WAIT_RELOAD = 3'd6;
	localparam int         HIST_DEPTH      = 4;

	localparam logic [5:0] KEY_ENTER = 6'b000001;
	localparam logic [5:0] KEY_ESC   = 6'b000010;
	localparam logic [5:0] KEY_RIGHT = 6'b000100;
	localparam logic [5:0] KEY_UP    = 6'b001000;
	localparam logic [5:0] KEY_DOWN  = 6'b010000;
	localparam logic [5:0] KEY_LEFT  = 6'b100000;

	localparam logic [1:0] FIELD_SEC  = 2'd0;
	localparam logic [1:0] FIELD_MIN  = 2'd1;
	localparam logic [1:0] FIELD_HOUR = 2'd2;

	typedef struct packed {
		logic [5:0] sec;
		logic [5:0] min;
		logic [4:0] hour;
	} hms_t;

	typedef struct packed {
		logic [NUM_DIGITS-1:0] digit_select;
		logic [6:0]            segments;
		logic                  display_on;
		logic                  second_led;
		hms_t                  tm;
		logic                  setting_mode;
	} result_t;

	function automatic hms_t hours_up(hms_t t);
		hms_t r;
		r = t;
		r.hour = (t.hour >= HOUR_LAST) ? 5'd0 : t.hour + 5'd1;
		return r;
	endfunction

	function automatic hms_t hours_down(hms_t t);
		hms_t r;
		r = t;
		r.hour = (t.hour == 5'd0 || t.hour > HOUR_LAST) ? HOUR_LAST : t.hour - 5'd1;
		return r;
	endfunction

	function automatic hms_t minutes_up(hms_t t);
		hms_t r;
		r = t;
		if (t.min >= MIN_LAST) begin
			r.min = 6'd0;
			r = hours_up(r);
		end else begin
			r.min = t.min + 6'd1;
		end
		return r;
	endfunction

	function automatic hms_t minutes_down(hms_t t);
		hms_t r;
		r = t;
		if (t.min == 6'd0 || t.min > MIN_LAST) begin
			r.min = MIN_LAST;
			r = hours_down(r);
		end else begin
			r.min = t.min - 6'd1;
		end
		return r;
	endfunction

	function automatic hms_t seconds_up(hms_t t);
		hms_t r;
		r = t;
		if (t.sec >= SEC_LAST) begin
			r.sec = 6'd0;
			r = minutes_up(r);
		end else begin
			r.sec = t.sec + 6'd1;
		end
		return r;
	endfunction

	function automatic hms_t seconds_down(hms_t t);
		hms_t r;
		r = t;
		if (t.sec == 6'd0 || t.sec > SEC_LAST) begin
			r.sec = SEC_LAST;
			r = minutes_down(r);
		end else begin
			r.sec = t.sec - 6'd1;
		end
		return r;
	endfunction

	function automatic logic [2:0] tens_of(logic [5:0] v);
		logic [2:0] t;
		if (v >= 6'd60)      t = 3'd6;
		else if (v >= 6'd50) t = 3'd5;
		else if (v >= 6'd40) t = 3'd4;
		else if (v >= 6'd30) t = 3'd3;
		else if (v >= 6'd20) t = 3'd2;
		else if (v >= 6'd10) t = 3'd1;
		else                 t = 3'd0;
		return t;
	endfunction

	function automatic logic [3:0] ones_of(logic [5:0] v);
		logic [5:0] r;
		r = v - {3'd0, tens_of(v)} * 6'd10;
		return r[3:0];
	endfunction

	function automatic logic [6:0] seg_font(logic [3:0] n);
		logic [6:0] s;
		case (n)
			4'd0:    s = 7'b0111111;
			4'd1:    s = 7'b0000110;
			4'd2:    s = 7'b1011011;
			4'd3:    s = 7'b1001111;
			4'd4:    s = 7'b1100110;
			4'd5:    s = 7'b1101101;
			4'd6:    s = 7'b1111101;
			4'd7:    s = 7'b0000111;
			4'd8:    s = 7'b1111111;
			4'd9:    s = 7'b1101111;
			default: s = 7'b0000000;
		endcase
		return s;
	endfunction

	function automatic logic [6:0] digit_seg(hms_t t, logic [2:0] d);
		logic [5:0] v;
		logic [3:0] n;
		v = (d < 3'd2) ? t.sec : (d < 3'd4) ? t.min : {1'b0, t.hour};
		n = d[0] ? {1'b0, tens_of(v)} : ones_of(v);
		return seg_font(n);
	endfunction

endpackage

`default_nettype wire

// File: hdl/scs_in_stage.sv
// ----------------------------------------------------------------------------
// scs_in_stage
// Input register: holds one tick item until the clock core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module scs_in_stage (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	output logic in_stall,
	input  wire  key_pressed,
	input  wire  take,
	output logic valid_s1,
	output logic key_s1
);
	import scs_pkg::*;

	logic accept;

	assign in_stall = valid_s1 && !take;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_s1 <= key_pressed;
		end
	end

endmodule

`default_nettype wire

// File: hdl/scs_clock_core.sv
// ----------------------------------------------------------------------------
// scs_clock_core
// Clock state, digit scan, key debounce and edit logic; one step per item.
// ----------------------------------------------------------------------------
`default_nettype none
`include "settable_clock_display_scanner_macros.svh"

module scs_clock_core (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             cfg_we,
	input  wire [9:0]       cfg_wdata,
	input  wire             step,
	input  wire             key_in,
	output scs_pkg::result_t res
);
	import scs_pkg::*;

	logic [9:0]         reload_q;
	hms_t               tm_q, tm;
	logic               set_q, setm;
	logic [1:0]         field_q, field;
	logic [9:0]         tick_q, tick;
	logic [2:0]         scan_q, scan;
	logic [BLINK_W-1:0] blink_q, blink;
	logic [5:0]         hist_q [HIST_DEPTH];
	logic [5:0]         hist   [HIST_DEPTH];
	logic [2:0]         kw_q, kw;
	logic               led_q, led;
	logic [NUM_DIGITS-1:0] sel;
	logic [6:0]         seg;
	logic               lit;
	logic [5:0]         key;

	always_comb begin
		tm    = tm_q;
		setm  = set_q;
		field = field_q;
		tick  = tick_q;
		scan  = scan_q;
		blink = blink_q;
		hist  = hist_q;
		kw    = kw_q;
		led   = led_q;

		// run-mode second count
		if (!set_q) begin
			if (tick != 10'd0) begin
				tick = tick - 10'd1;
			end else begin
				tick = reload_q;
				led  = !led;
				tm   = seconds_up(tm);
			end
		end

		// shift key history
		if (kw == 3'd0) begin
			kw      = KEY_WAIT_RELOAD;
			hist[3] = hist[2];
			hist[2] = hist[1];
			hist[1] = hist[0];
			hist[0] = 6'd0;
		end

		if (scan >= SCAN_WRAP) begin
			scan  = 3'd0;
			blink = (blink >= BLINK_W'(BLINK_LAST)) ? '0 : blink + BLINK_W'(1);
		end

		sel = NUM_DIGITS'(1) << scan;
		seg = digit_seg(tm, scan);
		lit = !set_q || (scan[2:1] == field_q) || (blink == '0);

		if (key_in) begin
			hist[0] = hist[0] | sel;
			kw      = 3'd1;
		end

		key = hist[0];
		if (hist[0] == hist[1] && hist[0] == hist[2] && hist[0] != hist[3] &&
			hist[0] != 6'd0) begin
			if (key == KEY_ESC) begin
				setm = 1'b0;
				tick = reload_q;
			end
			if (key == KEY_ENTER) begin
				setm  = 1'b1;
				field = FIELD_SEC;
			end
			if (setm) begin
				case (key)
					KEY_RIGHT: field = (field == FIELD_SEC) ? FIELD_HOUR : field - 2'd1;
					KEY_LEFT:  field = (field >= FIELD_HOUR) ? FIELD_SEC : field + 2'd1;
					KEY_UP: begin
						case (field)
							FIELD_SEC:  tm = seconds_up(tm);
							FIELD_MIN:  tm = minutes_up(tm);
							FIELD_HOUR: tm = hours_up(tm);
							default:    ;
						endcase
					end
					KEY_DOWN: begin
						case (field)
							FIELD_SEC:  tm = seconds_down(tm);
							FIELD_MIN:  tm = minutes_down(tm);
							FIELD_HOUR: tm = hours_down(tm);
							default:    ;
						endcase
					end
					default: ;
				endcase
			end
		end

		scan = scan + 3'd1;
		kw   = kw - 3'd1;

		res.digit_select = sel;
		res.segments     = seg;
		res.display_on   = lit;
		res.second_led   = led;
		res.tm           = tm;
		res.setting_mode = setm;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= RELOAD_RESET;
		end else if (cfg_we) begin
			reload_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tm_q    <= '{sec: SEC_RESET, min: MIN_RESET, hour: HOUR_RESET};
			set_q   <= 1'b0;
			field_q <= FIELD_SEC;
			tick_q  <= TICK_RESET;
			scan_q  <= 3'd0;
			blink_q <= '0;
			hist_q  <= '{default: 6'd0};
			kw_q    <= KEY_WAIT_RELOAD;
			led_q   <= 1'b1;
		end else if (step) begin
			tm_q    <= tm;
			set_q   <= setm;
			field_q <= field;
			tick_q  <= tick;
			scan_q  <= scan;
			blink_q <= blink;
			hist_q  <= hist;
			kw_q    <= kw;
			led_q   <= led;
		end
	end

	`SCS_ASSERT_ALWAYS(a_scan_range, scan_q <= SCAN_WRAP, "scan digit out of range")
	`SCS_ASSERT_ALWAYS(a_field_range, field_q <= FIELD_HOUR, "edit field out of range")
	`SCS_ASSERT_ALWAYS(a_time_range,
		tm_q.sec <= SEC_LAST && tm_q.min <= MIN_LAST && tm_q.hour <= HOUR_LAST,
		"time out of range")
	`SCS_ASSERT_NEXT(a_hold_idle, !step, $stable(tm_q) && $stable(scan_q) && $stable(kw_q),
		"state moved without an item")

endmodule

`default_nettype wire

// File: hdl/scs_out_stage.sv
// ----------------------------------------------------------------------------
// scs_out_stage
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module scs_out_stage (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              load,
	input  scs_pkg::result_t res_in,
	output logic             free,
	output logic             out_valid,
	input  wire              out_stall,
	output scs_pkg::result_t res_q
);
	import scs_pkg::*;

	assign free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

`default_nettype wire

// File: hdl/settable_clock_display_scanner.sv
// ----------------------------------------------------------------------------
// settable_clock_display_scanner
// Settable 24-hour clock with six-digit display scan and debounced keypad.
// ----------------------------------------------------------------------------
// channel | handshake              | payload
// in      | in_valid / in_stall    | key_pressed
// out     | out_valid / out_stall  | digit_select segments display_on second_led
//         |                        | seconds minutes hours setting_mode
// cfg     | cfg_we                 | cfg_wdata (tick_reload)
//
// One item per clock while the output does not stall. A tick waits in the
// input register; the clock core works on it combinationally and its
// result is registered in the output register when the core takes the
// tick. Valid flags and all clock state reset asynchronously on arst_n
// low. A stalled result holds; the input register still takes one item
// behind it, then the input stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module settable_clock_display_scanner (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       cfg_we,
	input  wire [9:0] cfg_wdata,
	input  wire       in_valid,
	output logic      in_stall,
	input  wire       key_pressed,
	output logic      out_valid,
	input  wire       out_stall,
	output logic [5:0] digit_select,
	output logic [6:0] segments,
	output logic      display_on,
	output logic      second_led,
	output logic [5:0] seconds,
	output logic [5:0] minutes,
	output logic [4:0] hours,
	output logic      setting_mode
);
	import scs_pkg::*;

	logic    valid_s1;
	logic    key_s1;
	logic    free;
	logic    take;
	result_t res_d;
	result_t res_q;

	assign take = valid_s1 && free;

	scs_in_stage u_in (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.key_pressed (key_pressed),
		.take        (take),
		.valid_s1    (valid_s1),
		.key_s1      (key_s1)
	);

	scs_clock_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (take),
		.key_in    (key_s1),
		.res       (res_d)
	);

	scs_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.res_in    (res_d),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_q     (res_q)
	);

	assign digit_select = res_q.digit_select;
	assign segments     = res_q.segments;
	assign display_on   = res_q.display_on;
	assign second_led   = res_q.second_led;
	assign seconds      = res_q.tm.sec;
	assign minutes      = res_q.tm.min;
	assign hours        = res_q.tm.hour;
	assign setting_mode = res_q.setting_mode;

endmodule

`default_nettype wire

// File: tb/sv/tb_settable_clock_display_scanner.sv
// ----------------------------------------------------------------------------
// tb_settable_clock_display_scanner
// Self-checking bench for the settable clock with display scan and keypad.
// ----------------------------------------------------------------------------
// Feeds 1 ms ticks carrying the keypad return line. A short stimulus table
// steps through the reset display, an enter press and set-mode blinking.
// Random phases follow, one per tick reload setting. Most of each phase is
// debounced key presses, aimed at the scanned digit. The rest is line noise
// and presses too short to count. Results not set by the table are checked
// against a cycle-true clock model. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb_settable_clock_display_scanner;

	import scs_pkg::*;

	localparam logic [5:0] KEY_NONE   = 6'b000000;
	localparam int         IDLE_LIMIT = 2000;

	typedef struct packed {
		logic [5:0] digit_select;
		logic [6:0] segments;
		logic       display_on;
		logic       second_led;
		logic [5:0] seconds;
		logic [5:0] minutes;
		logic [4:0] hours;
		logic       setting_mode;
	} tick_view_t;

	typedef struct packed {
		logic [5:0] press_on;
		logic       typed;
		tick_view_t want;
	} tick_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [9:0] cfg_wdata = 10'd0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       key_pressed = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [5:0] digit_select;
	logic [6:0] segments;
	logic       display_on;
	logic       second_led;
	logic [5:0] seconds;
	logic [5:0] minutes;
	logic [4:0] hours;
	logic       setting_mode;

	settable_clock_display_scanner u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.key_pressed  (key_pressed),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.digit_select (digit_select),
		.segments     (segments),
		.display_on   (display_on),
		.second_led   (second_led),
		.seconds      (seconds),
		.minutes      (minutes),
		.hours        (hours),
		.setting_mode (setting_mode)
	);

	logic [9:0]         reload;
	logic [9:0]         tick_cnt;
	logic [5:0]         secs;
	logic [5:0]         mins;
	logic [4:0]         hrs;
	logic               editing;
	logic [1:0]         field_sel;
	logic [2:0]         scan_pos;
	logic [BLINK_W-1:0] blink_cnt;
	logic [5:0]         key_rows [HIST_DEPTH];
	logic [2:0]         shift_wait;
	logic               led;

	tick_view_t pending_views [$];
	tick_row_t  plan [0:24];
	logic       row_typed = 1'b0;
	tick_view_t row_want = '0;
	int         mismatches = 0;
	int         ticks_sent = 0;
	int         burst_left = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic void bump_hours(input bit up);
		if (up) hrs = (hrs >= HOUR_LAST) ? 5'd0 : hrs + 5'd1;
		else hrs = (hrs == 5'd0 || hrs > HOUR_LAST) ? HOUR_LAST : hrs - 5'd1;
	endfunction

	function automatic void bump_minutes(input bit up);
		if (up && mins >= MIN_LAST) begin
			mins = 6'd0;
			bump_hours(up);
		end else if (!up && (mins == 6'd0 || mins > MIN_LAST)) begin
			mins = MIN_LAST;
			bump_hours(up);
		end else begin
			mins = up ? mins + 6'd1 : mins - 6'd1;
		end
	endfunction

	function automatic void bump_seconds(input bit up);
		if (up && secs >= SEC_LAST) begin
			secs = 6'd0;
			bump_minutes(up);
		end else if (!up && (secs == 6'd0 || secs > SEC_LAST)) begin
			secs = SEC_LAST;
			bump_minutes(up);
		end else begin
			secs = up ? secs + 6'd1 : secs - 6'd1;
		end
	endfunction

	function automatic tick_view_t advance_clock(input logic key);
		tick_view_t v;
		logic [5:0] val;
		int         n;
		bit         up;
		if (!editing) begin
			if (tick_cnt != 10'd0) begin
				tick_cnt = tick_cnt - 10'd1;
			end else begin
				tick_cnt = reload;
				led = ~led;
				bump_seconds(1'b1);
			end
		end
		if (shift_wait == 3'd0) begin
			shift_wait = KEY_WAIT_RELOAD;
			key_rows[3] = key_rows[2];
			key_rows[2] = key_rows[1];
			key_rows[1] = key_rows[0];
			key_rows[0] = KEY_NONE;
		end
		if (scan_pos >= SCAN_WRAP) begin
			scan_pos = 3'd0;
			blink_cnt = (blink_cnt >= BLINK_LAST) ? '0 : blink_cnt + 1'b1;
		end
		v.digit_select = 6'd1 << scan_pos;
		val = (scan_pos < 3'd2) ? secs : (scan_pos < 3'd4) ? mins : {1'b0, hrs};
		n = scan_pos[0] ? val / 10 : val % 10;
		case (n)
			0: v.segments = 7'b0111111;
			1: v.segments = 7'b0000110;
			2: v.segments = 7'b1011011;
			3: v.segments = 7'b1001111;
			4: v.segments = 7'b1100110;
			5: v.segments = 7'b1101101;
			6: v.segments = 7'b1111101;
			7: v.segments = 7'b0000111;
			8: v.segments = 7'b1111111;
			9: v.segments = 7'b1101111;
			default: v.segments = 7'b0000000;
		endcase
		v.display_on = !editing || (scan_pos >> 1) == {1'b0, field_sel} || blink_cnt == '0;
		if (key) begin
			key_rows[0] = key_rows[0] | v.digit_select;
			shift_wait = 3'd1;
		end
		if (key_rows[0] == key_rows[1] && key_rows[0] == key_rows[2] &&
				key_rows[0] != key_rows[3] && key_rows[0] != KEY_NONE) begin
			up = (key_rows[0] == KEY_UP);
			case (key_rows[0])
				KEY_ESC: begin
					editing = 1'b0;
					tick_cnt = reload;
				end
				KEY_ENTER: begin
					editing = 1'b1;
					field_sel = FIELD_SEC;
				end
				KEY_RIGHT: begin
					if (editing) field_sel = (field_sel == FIELD_SEC) ? FIELD_HOUR : field_sel - 2'd1;
				end
				KEY_LEFT: begin
					if (editing) field_sel = (field_sel >= FIELD_HOUR) ? FIELD_SEC : field_sel + 2'd1;
				end
				KEY_UP, KEY_DOWN: begin
					if (editing) begin
						case (field_sel)
							FIELD_SEC:  bump_seconds(up);
							FIELD_MIN:  bump_minutes(up);
							FIELD_HOUR: bump_hours(up);
							default: ;
						endcase
					end
				end
				default: ;
			endcase
		end
		scan_pos = scan_pos + 3'd1;
		shift_wait = shift_wait - 3'd1;
		v.second_led = led;
		v.seconds = secs;
		v.minutes = mins;
		v.hours = hrs;
		v.setting_mode = editing;
		return v;
	endfunction

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : scoreboard
		tick_view_t want;
		tick_view_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{digit_select, segments, display_on, second_led,
					seconds, minutes, hours, setting_mode};
				if (pending_views.size() == 0) begin
					mismatches++;
					$display("%0t result expected none actual %h", $time, got);
				end else begin
					want = pending_views.pop_front();
					check_field("digit_select", want.digit_select, got.digit_select);
					check_field("segments", want.segments, got.segments);
					check_field("display_on", want.display_on, got.display_on);
					check_field("second_led", want.second_led, got.second_led);
					check_field("seconds", want.seconds, got.seconds);
					check_field("minutes", want.minutes, got.minutes);
					check_field("hours", want.hours, got.hours);
					check_field("setting_mode", want.setting_mode, got.setting_mode);
				end
			end
			if (in_valid && !in_stall) begin
				want = advance_clock(key_pressed);
				pending_views.push_back(row_typed ? row_want : want);
			end
		end
	end

	initial begin : receiver
		int hold;
		forever begin
			hold = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
			out_stall <= 1'b0;
			repeat (hold) @(negedge clk);
			hold = $urandom_range(1, 12);
			out_stall <= 1'b1;
			repeat (hold) @(negedge clk);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
			else quiet++;
		end
		$display("FAIL");
		$finish;
	end

	task automatic send_tick(input logic [5:0] press_on);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : $urandom_range(0, 3);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		ticks_sent++;
		key_pressed <= press_on[(scan_pos >= SCAN_WRAP) ? 3'd0 : scan_pos];
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic gesture(input logic [5:0] key, input int scans);
		repeat (scans * NUM_DIGITS) send_tick(key);
		repeat ($urandom_range(8, 16)) send_tick(KEY_NONE);
	endtask

	task automatic write_reload(input logic [9:0] value);
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_views.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		reload = value;
	endtask

	task automatic run_phase(input int count);
		int first;
		int pick;
		first = ticks_sent;
		gesture(KEY_ESC, 3);
		while (ticks_sent - first < count) begin
			pick = $urandom_range(0, 99);
			if (!editing) begin
				if (pick < 40) begin
					// line up enter so the edit lands near a minute boundary
					if (reload == 10'd0) begin
						for (int i = 0; i < 60 && secs != 6'd40; i++) send_tick(KEY_NONE);
					end
					gesture(KEY_ENTER, 3);
				end else if (pick < 50) begin
					gesture(KEY_ESC, 3);
				end else if (pick < 60) begin
					gesture(6'd1 << $urandom_range(2, 5), 3);
				end else if (pick < 75) begin
					repeat ($urandom_range(5, 40)) send_tick(KEY_NONE);
				end else if (pick < 88) begin
					repeat ($urandom_range(5, 30)) send_tick(6'($urandom));
				end else begin
					gesture(6'($urandom), $urandom_range(1, 4));
				end
			end else begin
				if (pick < 35) gesture(KEY_UP, $urandom_range(3, 4));
				else if (pick < 60) gesture(KEY_DOWN, 3);
				else if (pick < 70) gesture(KEY_LEFT, 3);
				else if (pick < 80) gesture(KEY_RIGHT, 3);
				else if (pick < 86) gesture(KEY_ESC, 3);
				else if (pick < 89) gesture(KEY_ENTER, 3);
				else if (pick < 95) repeat ($urandom_range(5, 30)) send_tick(6'($urandom));
				else gesture(6'($urandom), $urandom_range(1, 2));
			end
		end
	endtask

	initial begin : stimulus
		reload = RELOAD_RESET;
		tick_cnt = TICK_RESET;
		secs = SEC_RESET;
		mins = MIN_RESET;
		hrs = HOUR_RESET;
		editing = 1'b0;
		field_sel = FIELD_SEC;
		scan_pos = 3'd0;
		blink_cnt = '0;
		foreach (key_rows[i]) key_rows[i] = KEY_NONE;
		shift_wait = KEY_WAIT_RELOAD;
		led = 1'b1;

		plan = '{
			'{KEY_NONE,  1'b1, '{6'b000001, 7'b1100110, 1'b1, 1'b1, 6'd24, 6'd35, 5'd22, 1'b0}},
			'{KEY_NONE,  1'b1, '{6'b000010, 7'b1011011, 1'b1, 1'b1, 6'd24, 6'd35, 5'd22, 1'b0}},
			'{KEY_NONE,  1'b1, '{6'b000100, 7'b1101101, 1'b1, 1'b1, 6'd24, 6'd35, 5'd22, 1'b0}},
			'{KEY_NONE,  1'b1, '{6'b001000, 7'b1001111, 1'b1, 1'b1, 6'd24, 6'd35, 5'd22, 1'b0}},
			'{KEY_NONE,  1'b1, '{6'b010000, 7'b1011011, 1'b1, 1'b1, 6'd24, 6'd35, 5'd22, 1'b0}},
			'{KEY_NONE,  1'b1, '{6'b100000, 7'b1011011, 1'b1, 1'b1, 6'd24, 6'd35, 5'd22, 1'b0}},
			'{KEY_ENTER, 1'b0, '0},
			'{KEY_ENTER, 1'b0, '0},
			'{KEY_ENTER, 1'b0, '0},
			'{KEY_ENTER, 1'b0, '0},
			'{KEY_ENTER, 1'b0, '0},
			'{KEY_ENTER, 1'b0, '0},
			'{KEY_ENTER, 1'b0, '0},
			'{KEY_ENTER, 1'b0, '0},
			'{KEY_ENTER, 1'b0, '0},
			'{KEY_ENTER, 1'b0, '0},
			'{KEY_ENTER, 1'b0, '0},
			'{KEY_ENTER, 1'b0, '0},
			'{KEY_ENTER, 1'b1, '{6'b000001, 7'b1100110, 1'b1, 1'b1, 6'd24, 6'd35, 5'd22, 1'b1}},
			'{KEY_NONE,  1'b0, '0},
			'{KEY_NONE,  1'b1, '{6'b000100, 7'b1101101, 1'b0, 1'b1, 6'd24, 6'd35, 5'd22, 1'b1}},
			'{KEY_NONE,  1'b0, '0},
			'{KEY_NONE,  1'b0, '0},
			'{KEY_NONE,  1'b0, '0},
			'{KEY_NONE,  1'b0, '0}
		};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			row_typed = plan[i].typed;
			row_want = plan[i].want;
			send_tick(plan[i].press_on);
		end
		row_typed = 1'b0;

		write_reload(10'd0);
		run_phase(350);
		write_reload(10'd1023);
		run_phase(120);
		write_reload(10'd2);
		run_phase(250);
		write_reload(10'($urandom_range(0, 31)));
		run_phase(250);
		write_reload(10'd0);
		run_phase(250);

		in_valid <= 1'b0;
		while (pending_views.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		if (mismatches == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule
